// File: hw/rtl/lphr_pkg.sv
// Shared types and constants of the linear probing hash table with rehash.
// Used by the top level and lphr_mod; depends on nothing.
`timescale 1ns / 1ps
package lphr_pkg;

  localparam int CAPACITY = 32;
  localparam int KEY_W  = 16;
  localparam int VAL_W  = 32;
  localparam int SIZE_W = 6;
  localparam int SLOT_W = 5;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REHASH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd3;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_GROWN = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_RD,
    S_CNT,
    S_RH_SCAN,
    S_RH_WAIT,
    S_DONE
  } state_t;

endpackage

// File: hw/rtl/linear_probe_hash_rehash_unit.sv
// Top level of the linear probing hash table with two-bank rehash.
// Depends on lphr_pkg, lphr_mod and lphr_mem.
`timescale 1ns / 1ps
// Usage: one item on the in_ channel carries a command in in_tuser and key, value
// and slot in in_tdata. Each item gives exactly one result on the out_ channel,
// with the status in out_tuser and the slot, entry and active size in out_tdata.
// The block takes one item at a time; in_tready is high only while it is idle.
// An insert first lets the remainder unit resolve the home slot one key bit
// per cycle, then probes until it finds a free slot or has probed every slot.
// A read goes through the registered memory read port.
// A rehash first counts the entries in the active slots, then scans those slots
// and, for each occupied entry, resolves its home slot and probes the other bank.
// The cfg_ channel writes start_size (index 0) and grown_size (index 1) and is
// always ready; writing start_size empties the active bank at once.
// Reset clears all occupied marks, selects bank 0 and restores the sizes to 7
// and 14, with no clearing pass. A finished result waits in the output register
// while out_tready is low; the next item is still taken and processed, but its
// result then holds the block busy, with in_tready low, until the register frees.
module linear_probe_hash_rehash_unit #(
  parameter int KEY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // key [15:0], value [47:16], slot [52:48], zero fill up to 56 bits.
  input  logic [55:0] in_tdata,
  // command [1:0].
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // placed_slot [4:0], entry_key [20:5], entry_value [52:21], entry_used [53],
  // size_now [59:54], zero fill up to 64 bits.
  output logic [63:0] out_tdata,
  // status [1:0].
  output logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);
  localparam int CAPACITY = lphr_pkg::CAPACITY;
  localparam int KW = lphr_pkg::KEY_W;
  localparam int VW = lphr_pkg::VAL_W;
  localparam int SW = lphr_pkg::SIZE_W;
  localparam int PW = lphr_pkg::SLOT_W;
  localparam int STW = lphr_pkg::STAT_W;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int ADDR_W = IDX_W + 1;
  localparam int CW = ((IDX_W > SW) ? IDX_W : SW) + 1;
  localparam int NSLOT = 2 * CAPACITY;
  localparam logic [KW-1:0] KEY_MASK =
    (KEY_BITS >= KW) ? {KW{1'b1}} : KW'((64'd1 << KEY_BITS) - 64'd1);
  localparam logic [SW-1:0] START_RST = 6'd7;
  localparam logic [SW-1:0] GROWN_RST = 6'd14;

  function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    if (s == '0) begin
      r = SW'(1);
    end else if (CW'(s) > CW'(CAPACITY)) begin
      r = SW'(CAPACITY);
    end else begin
      r = s;
    end
    return r;
  endfunction

  lphr_pkg::state_t state_r, state_nxt;

  logic             bank_r, bank_nxt;
  logic [SW-1:0]    size_r, size_nxt;
  logic [SW-1:0]    grown_r, grown_nxt;
  logic [SW-1:0]    newsize_r, newsize_nxt;
  logic [NSLOT-1:0] used_r, used_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [SW-1:0]    cnt_r, cnt_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic [KW-1:0]    key_r, key_nxt;
  logic [VW-1:0]    val_r, val_nxt;
  logic [PW-1:0]    slot_r, slot_nxt;

  logic [STW-1:0]   res_status_r, res_status_nxt;
  logic [PW-1:0]    res_placed_r, res_placed_nxt;
  logic [KW-1:0]    res_key_r, res_key_nxt;
  logic [VW-1:0]    res_val_r, res_val_nxt;
  logic             res_used_r, res_used_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [STW-1:0]   out_status_r, out_status_nxt;
  logic [59:0]      out_data_r, out_data_nxt;

  logic             mod_start;
  logic [KW-1:0]    mod_dividend;
  logic [SW-1:0]    mod_divisor;
  logic             mod_done;
  logic [SW-1:0]    mod_rem;

  logic             wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [KW+VW-1:0] wr_data, rd_data;

  logic             in_acc;
  logic             probe_bank;
  logic [SW-1:0]    probe_size;
  logic [ADDR_W-1:0] probe_addr, scan_addr, slot_addr;
  logic             out_free;
  logic [SW:0]      cnt_sum;

  assign in_acc     = in_tvalid && in_tready;
  assign in_tready  = (state_r == lphr_pkg::S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign probe_bank = (cmd_r == lphr_pkg::CMD_REHASH) ? !bank_r : bank_r;
  assign probe_size = (cmd_r == lphr_pkg::CMD_REHASH) ? newsize_r : size_r;
  assign probe_addr = {probe_bank, idx_r};
  assign scan_addr  = {bank_r, i_r[IDX_W-1:0]};
  assign slot_addr  = {bank_r, IDX_W'(slot_r)};
  assign cnt_sum    = {1'b0, cnt_r} + (SW+1)'(used_r[scan_addr]);

  lphr_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (mod_divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  lphr_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (KW + VW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lphr_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            lphr_pkg::CMD_INSERT: state_nxt = lphr_pkg::S_MOD;
            lphr_pkg::CMD_REHASH: state_nxt = lphr_pkg::S_CNT;
            lphr_pkg::CMD_READ: begin
              if (CW'(in_tdata[52:48]) >= CW'(size_r)) begin
                state_nxt = lphr_pkg::S_DONE;
              end else begin
                state_nxt = lphr_pkg::S_RD;
              end
            end
            default: state_nxt = lphr_pkg::S_DONE;
          endcase
        end
      end
      lphr_pkg::S_MOD: begin
        if (mod_done) begin
          state_nxt = lphr_pkg::S_PROBE;
        end
      end
      lphr_pkg::S_PROBE: begin
        if (!used_r[probe_addr]) begin
          state_nxt = (cmd_r == lphr_pkg::CMD_REHASH) ? lphr_pkg::S_RH_SCAN
                                                       : lphr_pkg::S_DONE;
        end else if (n_r + 1'b1 == CW'(probe_size)) begin
          state_nxt = lphr_pkg::S_DONE;
        end
      end
      lphr_pkg::S_RD: state_nxt = lphr_pkg::S_DONE;
      lphr_pkg::S_CNT: begin
        if (i_r + 1'b1 == CW'(size_r)) begin
          state_nxt = (cnt_sum > (SW+1)'(newsize_r)) ? lphr_pkg::S_DONE
                                                      : lphr_pkg::S_RH_SCAN;
        end
      end
      lphr_pkg::S_RH_SCAN: begin
        if (i_r == CW'(size_r)) begin
          state_nxt = lphr_pkg::S_DONE;
        end else if (used_r[scan_addr]) begin
          state_nxt = lphr_pkg::S_RH_WAIT;
        end
      end
      lphr_pkg::S_RH_WAIT: state_nxt = lphr_pkg::S_MOD;
      lphr_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = lphr_pkg::S_IDLE;
        end
      end
      default: state_nxt = lphr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    bank_nxt       = bank_r;
    size_nxt       = size_r;
    grown_nxt      = grown_r;
    newsize_nxt    = newsize_r;
    used_nxt       = used_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    cnt_nxt        = cnt_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    slot_nxt       = slot_r;
    res_status_nxt = res_status_r;
    res_placed_nxt = res_placed_r;
    res_key_nxt    = res_key_r;
    res_val_nxt    = res_val_r;
    res_used_nxt   = res_used_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    mod_start      = 1'b0;
    mod_dividend   = key_r;
    mod_divisor    = probe_size;
    wr_en          = 1'b0;
    wr_addr        = probe_addr;
    wr_data        = {val_r, key_r};
    rd_en          = 1'b0;
    rd_addr        = scan_addr;

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == lphr_pkg::CFG_START) begin
        size_nxt  = clamp_size(cfg_data);
        for (int s = 0; s < CAPACITY; s++) begin
          used_nxt[{bank_r, IDX_W'(s)}] = 1'b0;
        end
      end else begin
        grown_nxt = cfg_data;
      end
    end

    case (state_r)
      lphr_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_nxt        = in_tuser;
          key_nxt        = in_tdata[15:0] & KEY_MASK;
          val_nxt        = in_tdata[47:16];
          slot_nxt       = in_tdata[52:48];
          n_nxt          = '0;
          i_nxt          = '0;
          cnt_nxt        = '0;
          newsize_nxt    = clamp_size(grown_r);
          res_status_nxt = lphr_pkg::ST_OK;
          res_placed_nxt = '0;
          res_key_nxt    = '0;
          res_val_nxt    = '0;
          res_used_nxt   = 1'b0;
          case (in_tuser)
            lphr_pkg::CMD_INSERT: begin
              mod_start    = 1'b1;
              mod_dividend = in_tdata[15:0] & KEY_MASK;
              mod_divisor  = size_r;
            end
            lphr_pkg::CMD_READ: begin
              if (CW'(in_tdata[52:48]) >= CW'(size_r)) begin
                res_status_nxt = lphr_pkg::ST_RANGE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = {bank_r, IDX_W'(in_tdata[52:48])};
              end
            end
            default: begin
            end
          endcase
        end
      end
      lphr_pkg::S_MOD: begin
        if (mod_done) begin
          idx_nxt = IDX_W'(mod_rem);
          n_nxt   = '0;
        end
      end
      lphr_pkg::S_PROBE: begin
        if (!used_r[probe_addr]) begin
          wr_en                = 1'b1;
          used_nxt[probe_addr] = 1'b1;
          res_placed_nxt       = PW'(idx_r);
          i_nxt                = i_r + 1'b1;
        end else begin
          n_nxt = n_r + 1'b1;
          if (n_r + 1'b1 == CW'(probe_size)) begin
            res_status_nxt = lphr_pkg::ST_FULL;
            res_placed_nxt = '0;
          end
          if (CW'(idx_r) + 1'b1 == CW'(probe_size)) begin
            idx_nxt = '0;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      lphr_pkg::S_RD: begin
        res_placed_nxt = slot_r;
        if (used_r[slot_addr]) begin
          res_key_nxt  = rd_data[KW-1:0];
          res_val_nxt  = rd_data[KW+VW-1:KW];
          res_used_nxt = 1'b1;
        end
      end
      lphr_pkg::S_CNT: begin
        cnt_nxt = cnt_sum[SW-1:0];
        i_nxt   = i_r + 1'b1;
        if (i_r + 1'b1 == CW'(size_r)) begin
          i_nxt = '0;
          if (cnt_sum > (SW+1)'(newsize_r)) begin
            res_status_nxt = lphr_pkg::ST_OVERFLOW;
          end else begin
            for (int s = 0; s < CAPACITY; s++) begin
              used_nxt[{!bank_r, IDX_W'(s)}] = 1'b0;
            end
          end
        end
      end
      lphr_pkg::S_RH_SCAN: begin
        if (i_r == CW'(size_r)) begin
          bank_nxt       = !bank_r;
          size_nxt       = newsize_r;
          res_placed_nxt = '0;
        end else if (used_r[scan_addr]) begin
          rd_en = 1'b1;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      lphr_pkg::S_RH_WAIT: begin
        key_nxt      = rd_data[KW-1:0];
        val_nxt      = rd_data[KW+VW-1:KW];
        mod_start    = 1'b1;
        mod_dividend = rd_data[KW-1:0];
        mod_divisor  = newsize_r;
      end
      lphr_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = {size_r, res_used_r, res_val_r, res_key_r, res_placed_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lphr_pkg::S_IDLE;
      bank_r      <= 1'b0;
      grown_r     <= GROWN_RST;
      size_r      <= clamp_size(START_RST);
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      grown_r     <= grown_nxt;
      size_r      <= size_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    newsize_r    <= newsize_nxt;
    idx_r        <= idx_nxt;
    n_r          <= n_nxt;
    i_r          <= i_nxt;
    cnt_r        <= cnt_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_placed_r <= res_placed_nxt;
    res_key_r    <= res_key_nxt;
    res_val_r    <= res_val_nxt;
    res_used_r   <= res_used_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {4'd0, out_data_r};

endmodule

// File: hw/rtl/lphr_mod.sv
// Bit-serial remainder unit: key modulo table size, one bit per cycle.
// Depends on lphr_pkg for the key and size widths.
`timescale 1ns / 1ps
module lphr_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lphr_pkg::KEY_W-1:0]  dividend,
  input  logic [lphr_pkg::SIZE_W-1:0] divisor,
  output logic                        done,
  output logic [lphr_pkg::SIZE_W-1:0] remainder
);
  localparam int KW = lphr_pkg::KEY_W;
  localparam int SW = lphr_pkg::SIZE_W;
  localparam int CNT_W = $clog2(KW + 1);

  logic [KW-1:0]    shift_r, shift_nxt;
  logic [SW-1:0]    div_r, div_nxt;
  logic [SW:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [SW:0]      trial;

  always_comb begin
    shift_nxt = shift_r;
    div_nxt   = div_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    trial     = {rem_r[SW-1:0], shift_r[KW-1]};
    if (start) begin
      shift_nxt = dividend;
      div_nxt   = divisor;
      rem_nxt   = '0;
      cnt_nxt   = CNT_W'(KW);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      rem_nxt   = (trial >= {1'b0, div_r}) ? trial - {1'b0, div_r} : trial;
      shift_nxt = {shift_r[KW-2:0], 1'b0};
      cnt_nxt   = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    shift_r <= shift_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r[SW-1:0];

endmodule

// File: hw/rtl/lphr_mem.sv
// Entry memory holding key and value of both banks, one write and one read port.
// Read data is registered; no package dependency.
`timescale 1ns / 1ps
module lphr_mem #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);
  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
